// ----- rtl/swbrm_pkg.sv -----
// Shared types and constants for the sliding-window byte rate meter.
// No dependencies; imported by sliding_window_byte_rate_meter_core.

package swbrm_pkg;

    // Field widths of the transfer payloads and the register
    localparam int WIN_W    = 7;
    localparam int BYTES_W  = 16;
    localparam int SLOT_W   = 40;
    localparam int TOTAL_W  = 48;
    localparam int STEP_W   = 3;
    localparam int SCALED_W = 20;

    // Ring geometry
    localparam int MAX_SLOTS_DEF = 64;
    localparam int MIN_SLOTS     = 5;
    localparam logic [WIN_W-1:0] WINDOW_RST = 7'd50;

    // Saturation limits
    localparam logic [SLOT_W-1:0]  SLOT_MAX  = {SLOT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Item operation codes
    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Display unit codes, powers of 1024
    localparam logic [STEP_W-1:0] UNIT_B   = 3'd0;
    localparam logic [STEP_W-1:0] UNIT_KIB = 3'd1;
    localparam logic [STEP_W-1:0] UNIT_MIB = 3'd2;
    localparam logic [STEP_W-1:0] UNIT_GIB = 3'd3;
    localparam logic [STEP_W-1:0] UNIT_TIB = 3'd4;

    typedef struct packed {
        op_t                op;
        logic [BYTES_W-1:0] byte_count;
    } meter_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  window_bytes;
        logic [STEP_W-1:0]   unit_step;
        logic [SCALED_W-1:0] scaled_value;
    } meter_out_t;

endpackage

// ----- rtl/sliding_window_byte_rate_meter_core.sv -----
// Sliding-window byte rate meter: ring of per-grain byte counters in a memory,
// saturating running total and power-of-1024 scaling. Depends on swbrm_pkg.
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_ready    in_data  (meter_in_t)
//   out       out   out_valid/out_ready  out_data (meter_out_t)
//   cfg       in    cfg_we               cfg_wdata (window_slots)
//
// One item per cycle sustained while out_ready holds; each result is registered
// twice: slot read from memory, then update into the output register.
// The slot read-modify-write sets the pace: a write-first bypass feeds the
// slot just updated to a following item that touches the same slot.
// Reset and a window write clear the meter at once; a flag for slot 0 and a
// fill count for the slots above it mark the slots that hold data, so no
// clearing pass is needed.
// A stalled output holds its result while one more item waits in the
// slot-read stage; in_ready drops only when both are occupied.

module sliding_window_byte_rate_meter_core
    import swbrm_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  meter_in_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output meter_out_t       out_data,
    input  logic             cfg_we,
    input  logic [WIN_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // Configuration and ring position
    logic [WIN_W-1:0]   window_reg;
    logic [IDX_W-1:0]   cur_slot_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               slot0_ok_reg;
    logic               slot0_ok_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    // Slot memory
    logic [SLOT_W-1:0]  slot_mem [MAX_SLOTS];
    logic [SLOT_W-1:0]  mem_rd_reg;

    // Slot-read stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [BYTES_W-1:0] s1_bytes_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    logic               s1_fwd_reg;
    logic [SLOT_W-1:0]  s1_fwd_data_reg;
    logic               s1_init_reg;

    // Output register
    logic               out_valid_reg;
    meter_out_t         out_data_reg;

    logic               accept;
    logic               s1_adv;
    logic [CMP_W-1:0]   win_ext;
    logic [CMP_W-1:0]   ring_len;
    logic [CMP_W-1:0]   cur_inc;
    logic [IDX_W-1:0]   tick_slot;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_hit;
    logic               rd_init;

    logic [SLOT_W-1:0]  slot_old;
    logic [SLOT_W-1:0]  slot_room;
    logic [SLOT_W-1:0]  gain;
    logic [SLOT_W-1:0]  slot_new;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] slot_as_total;
    logic [STEP_W-1:0]  step;
    logic [SCALED_W-1:0] scaled;

    // Handshake: stage advances when the output register is free or draining
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the window to the ring and find the slot after the current one
    always_comb
    begin
        win_ext = CMP_W'(window_reg);
        if (win_ext < CMP_W'(MIN_SLOTS))
        begin
            ring_len = CMP_W'(MIN_SLOTS);
        end
        else if (win_ext > CMP_W'(MAX_SLOTS))
        begin
            ring_len = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            ring_len = win_ext;
        end
        cur_inc = CMP_W'(cur_slot_reg) + CMP_W'(1);
        if (cur_inc >= ring_len)
        begin
            tick_slot = '0;
        end
        else
        begin
            tick_slot = cur_inc[IDX_W-1:0];
        end
        rd_addr = (in_data.op == OP_TICK) ? tick_slot : cur_slot_reg;
        wr_hit  = s1_adv && (s1_addr_reg == rd_addr);
        rd_init = (rd_addr == '0) ? slot0_ok_reg
                                  : (CMP_W'(rd_addr) < CMP_W'(fill_reg));
    end

    // Slot update and running total for the item in the read stage
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            slot_old = s1_fwd_data_reg;
        end
        else if (s1_init_reg)
        begin
            slot_old = mem_rd_reg;
        end
        else
        begin
            slot_old = '0;
        end
        slot_room     = SLOT_MAX - slot_old;
        gain          = (SLOT_W'(s1_bytes_reg) > slot_room) ? slot_room
                                                            : SLOT_W'(s1_bytes_reg);
        total_sum     = {1'b0, total_reg} + (TOTAL_W + 1)'(gain);
        slot_as_total = TOTAL_W'(slot_old);
        if (s1_op_reg == OP_TICK)
        begin
            slot_new   = '0;
            total_next = (total_reg >= slot_as_total) ? (total_reg - slot_as_total)
                                                      : '0;
        end
        else
        begin
            slot_new   = slot_old + gain;
            total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
        // Slot 0 keeps its own flag; above it, the write that touches the
        // first untouched slot extends the fill
        slot0_ok_next = slot0_ok_reg || (s1_addr_reg == '0);
        if (CMP_W'(s1_addr_reg) == CMP_W'(fill_reg))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    // Pick the unit and scale the total to 10 fraction bits
    always_comb
    begin
        if (|total_next[47:40])
        begin
            step = UNIT_TIB;
        end
        else if (|total_next[39:30])
        begin
            step = UNIT_GIB;
        end
        else if (|total_next[29:20])
        begin
            step = UNIT_MIB;
        end
        else if (|total_next[19:10])
        begin
            step = UNIT_KIB;
        end
        else
        begin
            step = UNIT_B;
        end
        unique case (step)
            UNIT_B:   scaled = {total_next[9:0], 10'd0};
            UNIT_KIB: scaled = total_next[19:0];
            UNIT_MIB: scaled = total_next[29:10];
            UNIT_GIB: scaled = total_next[39:20];
            UNIT_TIB: scaled = {2'd0, total_next[47:30]};
            default:  scaled = '0;
        endcase
    end

    // Slot memory: write back on advance, registered read on transfer in
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            slot_mem[s1_addr_reg] <= slot_new;
        end
        if (accept)
        begin
            mem_rd_reg <= slot_mem[rd_addr];
        end
    end

    // Read-stage payload, bypass of the slot written in the same cycle, and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= in_data.op;
            s1_bytes_reg    <= in_data.byte_count;
            s1_addr_reg     <= rd_addr;
            s1_fwd_reg      <= wr_hit;
            s1_fwd_data_reg <= slot_new;
            s1_init_reg     <= rd_init;
        end
        if (s1_adv)
        begin
            out_data_reg.window_bytes <= total_next;
            out_data_reg.unit_step    <= step;
            out_data_reg.scaled_value <= scaled;
        end
    end

    // Control state, window register, ring position, fill count and total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RST;
            cur_slot_reg  <= '0;
            fill_reg      <= CNT_W'(1);
            slot0_ok_reg  <= 1'b0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Restart the meter with the new window
            window_reg    <= cfg_wdata;
            cur_slot_reg  <= '0;
            fill_reg      <= CNT_W'(1);
            slot0_ok_reg  <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (accept && (in_data.op == OP_TICK))
            begin
                cur_slot_reg <= tick_slot;
            end
            if (s1_adv)
            begin
                total_reg    <= total_next;
                fill_reg     <= fill_next;
                slot0_ok_reg <= slot0_ok_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- test/sliding_window_byte_rate_meter_core_tb.sv -----
// Self-checking testbench for sliding_window_byte_rate_meter_core.
// Depends on swbrm_pkg and the core; predicts every result from its own copy of the
// grain ring and compares each output transfer field by field.
`timescale 1ns / 100ps

module sliding_window_byte_rate_meter_core_tb;
    import swbrm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    meter_in_t        in_data;
    logic             out_valid;
    logic             out_ready;
    meter_out_t       out_data;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    // Predicted state of the meter
    logic [SLOT_W-1:0]  grain_bytes [MAX_SLOTS_DEF];
    int unsigned        grain_index;
    logic [TOTAL_W-1:0] window_sum;
    logic [WIN_W-1:0]   window_setting;

    // Readings predicted for accepted transfers, oldest first
    meter_out_t pending_readings [$];

    // Idle control for both channels
    bit steady_send;
    bit steady_drain;
    int unsigned drain_hold;

    // Run statistics
    int unsigned fault_count;
    int unsigned items_sent;
    int unsigned ticks_sent;
    int unsigned readings_checked;
    int unsigned windows_written;
    int unsigned top_unit_seen;

    sliding_window_byte_rate_meter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run in case the handshake hangs
    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Clear the predicted ring, as reset and a window write do
    function automatic void clear_prediction();
        for (int i = 0; i < MAX_SLOTS_DEF; i++)
        begin
            grain_bytes[i] = '0;
        end
        grain_index = 0;
        window_sum  = '0;
    endfunction

    // Apply one item to the predicted ring and return the reading it produces
    function automatic meter_out_t advance_meter(input meter_in_t item);
        logic [SLOT_W-1:0] room;
        logic [SLOT_W-1:0] gain;
        logic [63:0]       total;
        int unsigned       ring;
        int unsigned       step;
        meter_out_t        reading;

        if (grain_index >= MAX_SLOTS_DEF)
        begin
            grain_index = 0;
        end
        if (item.op == OP_ADD)
        begin
            // Saturate the slot, then credit the total with what the slot gained
            room = SLOT_MAX - grain_bytes[grain_index];
            gain = (SLOT_W'(item.byte_count) > room) ? room : SLOT_W'(item.byte_count);
            grain_bytes[grain_index] = grain_bytes[grain_index] + gain;
            if (TOTAL_W'(gain) > TOTAL_MAX - window_sum)
            begin
                window_sum = TOTAL_MAX;
            end
            else
            begin
                window_sum = window_sum + TOTAL_W'(gain);
            end
        end
        else
        begin
            // Advance to the next slot, wrapping at the clamped ring length
            ring = window_setting;
            if (ring < MIN_SLOTS)
            begin
                ring = MIN_SLOTS;
            end
            if (ring > MAX_SLOTS_DEF)
            begin
                ring = MAX_SLOTS_DEF;
            end
            grain_index = grain_index + 1;
            if (grain_index >= ring)
            begin
                grain_index = 0;
            end
            // Drop the expired grain without going below zero
            if (window_sum >= TOTAL_W'(grain_bytes[grain_index]))
            begin
                window_sum = window_sum - TOTAL_W'(grain_bytes[grain_index]);
            end
            else
            begin
                window_sum = '0;
            end
            grain_bytes[grain_index] = '0;
        end

        // Pick the largest power-of-1024 unit that keeps the value at 1 or more
        total = 64'(window_sum);
        step  = 0;
        while (step < 4 && (total >> (10 * (step + 1))) != 0)
        begin
            step++;
        end
        reading.window_bytes = window_sum;
        reading.unit_step    = STEP_W'(step);
        if (step == 0)
        begin
            reading.scaled_value = SCALED_W'(total << 10);
        end
        else
        begin
            reading.scaled_value = SCALED_W'(total >> (10 * step - 10));
        end
        return reading;
    endfunction

    // Mostly short idle gaps, a few long ones
    function automatic int unsigned draw_idle_cycles();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Byte counts leaning toward large values so the total climbs into MiB
    function automatic logic [BYTES_W-1:0] draw_byte_count();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            return BYTES_W'($urandom_range(49152, 65535));
        end
        else if (roll < 40)
        begin
            return ($urandom_range(0, 1) != 0) ? {BYTES_W{1'b1}} : '0;
        end
        else if (roll < 80)
        begin
            return BYTES_W'($urandom());
        end
        return BYTES_W'($urandom_range(0, 255));
    endfunction

    // Send one item, with a random gap first, and record its predicted reading
    task automatic push_transfer(input op_t op, input logic [BYTES_W-1:0] byte_count);
        meter_in_t   item;
        int unsigned gap;

        item.op         = op;
        item.byte_count = byte_count;
        gap = steady_send ? 0 : draw_idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_readings.push_back(advance_meter(item));
        items_sent++;
        if (op == OP_TICK)
        begin
            ticks_sent++;
        end
    endtask

    // Stop sending and wait until every predicted reading has come back
    task automatic settle_meter();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the window register while the meter is idle
    task automatic program_window(input logic [WIN_W-1:0] value);
        settle_meter();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        window_setting = value;
        clear_prediction();
        windows_written++;
        cfg_we <= 1'b0;
    endtask

    // Report a field mismatch; only the first few in detail
    task automatic note_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Compare each output transfer with the oldest predicted reading
    always @(posedge clk)
    begin
        meter_out_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                note_fault("unexpected reading, window_bytes", '0, 64'(out_data.window_bytes));
            end
            else
            begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (want.unit_step > top_unit_seen)
                begin
                    top_unit_seen = want.unit_step;
                end
                if (out_data.window_bytes !== want.window_bytes)
                begin
                    note_fault("window_bytes", 64'(want.window_bytes),
                               64'(out_data.window_bytes));
                end
                if (out_data.unit_step !== want.unit_step)
                begin
                    note_fault("unit_step", 64'(want.unit_step), 64'(out_data.unit_step));
                end
                if (out_data.scaled_value !== want.scaled_value)
                begin
                    note_fault("scaled_value", 64'(want.scaled_value),
                               64'(out_data.scaled_value));
                end
            end
        end
    end

    // Stall the output side at random once out of reset
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (drain_hold > 0)
            begin
                out_ready <= 1'b0;
                drain_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                drain_hold = steady_drain ? 0 : draw_idle_cycles();
            end
        end
    end

    // Default window of 50 straight out of reset, both byte_count extremes
    task automatic test_power_on_window();
        push_transfer(OP_ADD, {BYTES_W{1'b1}});
        push_transfer(OP_ADD, '0);
        push_transfer(OP_ADD, 16'h0400);
        push_transfer(OP_TICK, {BYTES_W{1'b1}});
        push_transfer(OP_ADD, 16'd1);
        push_transfer(OP_TICK, '0);
    endtask

    // Smallest ring: wrap back to slot 0 and drop the oldest grains
    task automatic test_narrow_ring();
        program_window(WIN_W'(MIN_SLOTS));
        push_transfer(OP_ADD, 16'd1000);
        push_transfer(OP_TICK, '0);
        push_transfer(OP_ADD, 16'd2000);
        repeat (5) push_transfer(OP_TICK, '0);
    endtask

    // Window values outside 5..64 clamp to the nearest legal ring length
    task automatic test_clamped_window();
        program_window('0);
        push_transfer(OP_ADD, 16'd300);
        repeat (5) push_transfer(OP_TICK, '0);
        program_window({WIN_W{1'b1}});
        push_transfer(OP_ADD, 16'd50);
        push_transfer(OP_TICK, '0);
    endtask

    // Random traffic over several window settings and tick densities
    task automatic test_random_traffic();
        logic [WIN_W-1:0] windows [6];
        int unsigned      tick_pct [6];

        windows[0] = WIN_W'(MAX_SLOTS_DEF);
        windows[1] = WIN_W'(MIN_SLOTS);
        windows[2] = WIN_W'($urandom_range(MIN_SLOTS, MAX_SLOTS_DEF));
        windows[3] = WIN_W'($urandom_range(MAX_SLOTS_DEF + 1, 127));
        windows[4] = WIN_W'($urandom_range(0, MIN_SLOTS - 1));
        windows[5] = WIN_W'($urandom_range(0, 127));
        tick_pct[0] = 5;
        tick_pct[1] = 40;
        tick_pct[2] = 15;
        tick_pct[3] = 60;
        tick_pct[4] = 25;
        tick_pct[5] = 10;
        for (int phase = 0; phase < 6; phase++)
        begin
            program_window(windows[phase]);
            for (int n = 0; n < 92; n++)
            begin
                // Redraw idle behavior now and then so no-gap stretches occur
                if (n % 23 == 0)
                begin
                    steady_send  = ($urandom_range(0, 3) == 0);
                    steady_drain = ($urandom_range(0, 3) == 0);
                end
                // Hold off once mid-phase until the meter has caught up
                if (phase == 2 && n == 46)
                begin
                    settle_meter();
                end
                if ($urandom_range(0, 99) < tick_pct[phase])
                begin
                    push_transfer(OP_TICK, BYTES_W'($urandom()));
                end
                else
                begin
                    push_transfer(OP_ADD, draw_byte_count());
                end
            end
        end
        steady_send  = 1'b0;
        steady_drain = 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        out_ready      <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        steady_send    = 1'b0;
        steady_drain   = 1'b0;
        drain_hold     = 0;
        fault_count    = 0;
        items_sent     = 0;
        ticks_sent     = 0;
        readings_checked = 0;
        windows_written  = 0;
        top_unit_seen    = 0;
        window_setting = WINDOW_RST;
        clear_prediction();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_window();
        test_narrow_ring();
        test_clamped_window();
        test_random_traffic();

        // Drain the last readings and let the pipeline go quiet
        settle_meter();
        repeat (8) @(posedge clk);

        $display("Sent %0d items (%0d ticks), checked %0d readings over %0d window writes",
                 items_sent, ticks_sent, readings_checked, windows_written);
        $display("Largest display unit reached: %0d, mismatches: %0d",
                 top_unit_seen, fault_count);
        if (fault_count == 0 && pending_readings.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
